/* rtl/slc_pkg.sv */
// Shared types and constants for the scaled linear convolution block.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package slc_pkg;

	// Sizes of the tap store and the history line, and the sample precision.
	localparam int MAX_TAPS    = 256;
	localparam int SAMPLE_BITS = 16;

	// Field widths of the streaming items and of the configuration registers.
	localparam int CMD_W       = 2;
	localparam int IDX_W       = 8;
	localparam int VAL_W       = 16;
	localparam int OUT_W       = 24;
	localparam int TAP_COUNT_W = 9;
	localparam int SCALE_W     = 16;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 16;

	// Internal datapath widths.
	localparam int PTR_W   = $clog2(MAX_TAPS);
	localparam int PROD_W  = 2 * VAL_W;
	localparam int ACC_W   = PROD_W + PTR_W;
	localparam int SCL_W   = ACC_W + SCALE_W;
	localparam int SHIFT   = 2 * SAMPLE_BITS;

	localparam logic [VAL_W-1:0]   VAL_MASK  = VAL_W'((64'd1 << SAMPLE_BITS) - 64'd1);
	localparam logic [SCL_W:0]     RND_HALF  = (SCL_W + 1)'(1) << (SHIFT - 1);
	localparam logic [OUT_W-1:0]   OUT_MAX   = '1;
	localparam logic [TAP_COUNT_W-1:0] TAP_COUNT_RST = TAP_COUNT_W'(1);
	localparam logic [SCALE_W-1:0] SCALE_RST = SCALE_W'(655);

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_SCALE     = CFG_IDX_W'(1);

	// Input commands.
	typedef enum logic [CMD_W-1:0] {
		CMD_TAP   = 2'd0,
		CMD_PUSH  = 2'd1,
		CMD_CLEAR = 2'd2
	} cmd_t;

	// Controls from the sequencer to every lane.
	typedef struct packed {
		logic             tap_we;
		logic             hist_we;
		logic [PTR_W-1:0] wr_addr;
		logic             rd_en;
		logic             rd_first;
		logic             rd_vld;
		logic [PTR_W-1:0] rd_tap_addr;
		logic [PTR_W-1:0] rd_hist_addr;
		logic             fin;
	} ctl_t;

	// One channel's finished result.
	typedef struct packed {
		logic             valid;
		logic             sat;
		logic [OUT_W-1:0] value;
	} lane_res_t;

endpackage

`default_nettype wire

/* rtl/slc_ctrl.sv */
// Sequencer of the convolution block: input handshake, history pointer,
// history valid bits and the tap loop. Depends on slc_pkg.
`default_nettype none

module slc_ctrl (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             s_tvalid,
	output logic                            s_tready,
	input  wire  [slc_pkg::CMD_W-1:0]       cmd,
	input  wire  [slc_pkg::IDX_W-1:0]       tap_index,
	input  wire  [slc_pkg::TAP_COUNT_W-1:0] tap_count,
	input  wire                             out_free,
	output slc_pkg::ctl_t                   ctl
);

	typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN, ST_FIN} state_t;

	state_t                     state_q;
	logic [slc_pkg::PTR_W-1:0]  newest_q;
	logic [slc_pkg::PTR_W-1:0]  slot_q;
	logic [slc_pkg::PTR_W-1:0]  cnt_q;
	logic [slc_pkg::PTR_W-1:0]  last_q;
	logic                       dcnt_q;
	logic [slc_pkg::MAX_TAPS-1:0] hvalid_q;

	logic                       accept;
	logic                       tap_in_range;
	logic [slc_pkg::PTR_W-1:0]  ptr_next;
	logic [slc_pkg::PTR_W-1:0]  last_tap;
	logic [slc_pkg::PTR_W-1:0]  slot_prev;

	assign s_tready     = (state_q == ST_IDLE);
	assign accept       = s_tvalid && s_tready;
	assign tap_in_range = int'(tap_index) < slc_pkg::MAX_TAPS;
	assign ptr_next     = (newest_q == slc_pkg::PTR_W'(slc_pkg::MAX_TAPS - 1)) ?
	                      '0 : newest_q + 1'b1;
	assign slot_prev    = (slot_q == '0) ?
	                      slc_pkg::PTR_W'(slc_pkg::MAX_TAPS - 1) : slot_q - 1'b1;

	// A tap count of zero behaves as one, anything above the store as the full store.
	always_comb begin
		if (tap_count == '0) begin
			last_tap = '0;
		end else if (int'(tap_count) > slc_pkg::MAX_TAPS) begin
			last_tap = slc_pkg::PTR_W'(slc_pkg::MAX_TAPS - 1);
		end else begin
			last_tap = slc_pkg::PTR_W'(tap_count - 1'b1);
		end
	end

	always_comb begin
		ctl              = '0;
		ctl.rd_en        = (state_q == ST_RUN);
		ctl.rd_first     = (cnt_q == '0);
		ctl.rd_vld       = hvalid_q[slot_q];
		ctl.rd_tap_addr  = cnt_q;
		ctl.rd_hist_addr = slot_q;
		ctl.fin          = (state_q == ST_FIN) && out_free;
		ctl.wr_addr      = ptr_next;
		if (accept) begin
			case (slc_pkg::cmd_t'(cmd))
				slc_pkg::CMD_TAP: begin
					ctl.tap_we  = tap_in_range;
					ctl.wr_addr = slc_pkg::PTR_W'(tap_index);
				end
				slc_pkg::CMD_PUSH: begin
					ctl.hist_we = 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			newest_q <= '0;
			slot_q   <= '0;
			cnt_q    <= '0;
			last_q   <= '0;
			dcnt_q   <= 1'b0;
			hvalid_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (slc_pkg::cmd_t'(cmd))
							slc_pkg::CMD_PUSH: begin
								newest_q           <= ptr_next;
								slot_q             <= ptr_next;
								hvalid_q[ptr_next] <= 1'b1;
								cnt_q              <= '0;
								last_q             <= last_tap;
								state_q            <= ST_RUN;
							end
							slc_pkg::CMD_CLEAR: begin
								hvalid_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_RUN: begin
					cnt_q  <= cnt_q + 1'b1;
					slot_q <= slot_prev;
					if (cnt_q == last_q) begin
						dcnt_q  <= 1'b0;
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					// Wait for the read and product stages to empty.
					dcnt_q <= 1'b1;
					if (dcnt_q) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (cnt_q <= last_q))
		else $error("tap loop ran past the last tap in use");

	a_clear_all: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (cmd == slc_pkg::CMD_CLEAR)) |=> (hvalid_q == '0))
		else $error("history clear left a valid entry");

	a_push_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (cmd == slc_pkg::CMD_PUSH)) |=>
		(hvalid_q[newest_q] && (slot_q == newest_q) && (state_q == ST_RUN)))
		else $error("pushed sample not marked valid or loop not started at it");
`endif

endmodule

`default_nettype wire

/* rtl/slc_lane.sv */
// One channel lane: tap and history memories, multiply-accumulate over the
// taps, then scaling, rounding and saturation. Depends on slc_pkg.
`default_nettype none

module slc_lane (
	input  wire                           clk,
	input  wire                           arst_n,
	input  slc_pkg::ctl_t                 ctl,
	input  wire  [slc_pkg::VAL_W-1:0]     wdata,
	input  wire  [slc_pkg::SCALE_W-1:0]   scale,
	output slc_pkg::lane_res_t            res
);

	logic [slc_pkg::VAL_W-1:0]  tap_mem  [slc_pkg::MAX_TAPS];
	logic [slc_pkg::VAL_W-1:0]  hist_mem [slc_pkg::MAX_TAPS];

	logic [slc_pkg::VAL_W-1:0]  tap_rd_s1;
	logic [slc_pkg::VAL_W-1:0]  hist_rd_s1;
	logic                       vld_s1;
	logic                       en_s1;
	logic                       first_s1;
	logic [slc_pkg::PROD_W-1:0] prod_s2;
	logic                       en_s2;
	logic                       first_s2;
	logic [slc_pkg::ACC_W-1:0]  acc_q;
	logic [slc_pkg::SCL_W-1:0]  scaled_s4;
	logic                       fin_s4;
	logic [slc_pkg::SCL_W:0]    rnd;
	logic                       over;
	logic                       res_valid_q;
	logic                       res_sat_q;
	logic [slc_pkg::OUT_W-1:0]  res_value_q;

	always_ff @(posedge clk) begin
		if (ctl.tap_we) begin
			tap_mem[ctl.wr_addr] <= wdata;
		end
		tap_rd_s1 <= tap_mem[ctl.rd_tap_addr];
	end

	always_ff @(posedge clk) begin
		if (ctl.hist_we) begin
			hist_mem[ctl.wr_addr] <= wdata;
		end
		hist_rd_s1 <= hist_mem[ctl.rd_hist_addr];
	end

	// Entries that are not valid read as zero.
	always_ff @(posedge clk) begin
		vld_s1    <= ctl.rd_vld;
		prod_s2   <= tap_rd_s1 * (vld_s1 ? hist_rd_s1 : '0);
		scaled_s4 <= acc_q * scale;
		if (en_s2) begin
			acc_q <= first_s2 ? slc_pkg::ACC_W'(prod_s2) :
			         acc_q + slc_pkg::ACC_W'(prod_s2);
		end
	end

	assign rnd  = {1'b0, scaled_s4} + slc_pkg::RND_HALF;
	assign over = |rnd[slc_pkg::SCL_W:slc_pkg::OUT_W + slc_pkg::SHIFT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_s1       <= 1'b0;
			first_s1    <= 1'b0;
			en_s2       <= 1'b0;
			first_s2    <= 1'b0;
			fin_s4      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			en_s1       <= ctl.rd_en;
			first_s1    <= ctl.rd_first;
			en_s2       <= en_s1;
			first_s2    <= first_s1;
			fin_s4      <= ctl.fin;
			res_valid_q <= fin_s4;
		end
	end

	always_ff @(posedge clk) begin
		res_sat_q   <= over;
		res_value_q <= over ? slc_pkg::OUT_MAX : rnd[slc_pkg::SHIFT +: slc_pkg::OUT_W];
	end

	assign res = '{valid: res_valid_q, sat: res_sat_q, value: res_value_q};

endmodule

`default_nettype wire

/* rtl/slc_merge.sv */
// Merging stage: joins the three lane results into one output transaction
// and holds it in the output register. Depends on slc_pkg.
`default_nettype none

module slc_merge (
	input  wire                            clk,
	input  wire                            arst_n,
	input  slc_pkg::lane_res_t             res_r,
	input  slc_pkg::lane_res_t             res_g,
	input  slc_pkg::lane_res_t             res_b,
	input  wire                            m_tready,
	output logic                           m_tvalid,
	output logic [3*slc_pkg::OUT_W-1:0]    m_tdata,
	output logic                           m_tuser,
	output logic                           out_free
);

	logic m_tvalid_q;

	assign m_tvalid = m_tvalid_q;
	assign out_free = !(m_tvalid_q && !m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_r.valid) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_r.valid) begin
			m_tdata <= {res_b.value, res_g.value, res_r.value};
			m_tuser <= res_r.sat | res_g.sat | res_b.sat;
		end
	end

`ifndef NO_ASSERTIONS
	a_lanes_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		(res_r.valid == res_g.valid) && (res_g.valid == res_b.valid))
		else $error("lane results out of step");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res_r.valid |-> out_free)
		else $error("result arrived while the output register was held");

	a_sat_clipped: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && m_tuser) |->
		((m_tdata[0 +: slc_pkg::OUT_W] == slc_pkg::OUT_MAX) ||
		 (m_tdata[slc_pkg::OUT_W +: slc_pkg::OUT_W] == slc_pkg::OUT_MAX) ||
		 (m_tdata[2*slc_pkg::OUT_W +: slc_pkg::OUT_W] == slc_pkg::OUT_MAX)))
		else $error("saturation flagged without a clipped channel");
`endif

endmodule

`default_nettype wire

/* rtl/scaled_linear_convolution_top.sv */
// Top level of the scaled three-channel linear convolution block.
// Instantiates slc_ctrl, three slc_lane instances and slc_merge; uses slc_pkg.
//
// Usage. Input transactions arrive on the s_ group; s_tuser carries the
// command. A tap write stores one three-channel coefficient, a clear empties
// the history line, and a sample push enters one sample and yields exactly one
// output transaction on the m_ group with the three scaled Q8.16 sums and, in
// m_tuser, a flag that some channel was clipped. Other commands do nothing.
// Timing. Tap writes, clears and unused commands leave the block idle. A push keeps
// s_tready low while the block visits the n taps in use (tap_count, clamped to
// 1..256), drains its pipeline and waits for a free output register: each lane owns
// one tap memory and one history memory, each read at one address a cycle, and
// visits one tap a cycle. Configuration is written through cfg_we/cfg_index/cfg_data;
// the user must write it only while the block is idle; the block does not enforce it.
// Reset clears the history line, the pointers and the output
// valid flag, and sets tap_count to 1 and scale to 655; the tap store must be
// written before use. While a result waits for m_tready the block keeps taking
// input transactions; a following push holds its final stage until the output
// register is free, so no result is ever lost or overwritten.
`default_nettype none

module scaled_linear_convolution_top (
	input  wire                               clk,
	input  wire                               arst_n,
	// Input stream.
	input  wire                               s_tvalid,
	output logic                              s_tready,
	// s_tdata from bit 0 up: tap_index[7:0], value_r[15:0], value_g[15:0], value_b[15:0].
	input  wire  [55:0]                       s_tdata,
	// s_tuser from bit 0 up: command[1:0].
	input  wire  [slc_pkg::CMD_W-1:0]         s_tuser,
	// Output stream.
	output logic                              m_tvalid,
	input  wire                               m_tready,
	// m_tdata from bit 0 up: out_r[23:0], out_g[23:0], out_b[23:0].
	output logic [3*slc_pkg::OUT_W-1:0]       m_tdata,
	// m_tuser from bit 0 up: saturated.
	output logic                              m_tuser,
	// Configuration write port.
	input  wire                               cfg_we,
	input  wire  [slc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire  [slc_pkg::CFG_DATA_W-1:0]    cfg_data
);

	logic [slc_pkg::TAP_COUNT_W-1:0] tap_count_q;
	logic [slc_pkg::SCALE_W-1:0]     scale_q;

	slc_pkg::ctl_t       ctl;
	slc_pkg::lane_res_t  res_r;
	slc_pkg::lane_res_t  res_g;
	slc_pkg::lane_res_t  res_b;
	logic                out_free;

	logic [slc_pkg::IDX_W-1:0] tap_index;
	logic [slc_pkg::VAL_W-1:0] val_r;
	logic [slc_pkg::VAL_W-1:0] val_g;
	logic [slc_pkg::VAL_W-1:0] val_b;

	// Unpack the input fields; each value is masked to the sample precision, which here keeps all 16 bits.
	assign tap_index = s_tdata[7:0];
	assign val_r     = s_tdata[23:8]  & slc_pkg::VAL_MASK;
	assign val_g     = s_tdata[39:24] & slc_pkg::VAL_MASK;
	assign val_b     = s_tdata[55:40] & slc_pkg::VAL_MASK;

	// Configuration registers. Writes are expected only while the block is idle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q <= slc_pkg::TAP_COUNT_RST;
			scale_q     <= slc_pkg::SCALE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				slc_pkg::REG_TAP_COUNT: tap_count_q <= cfg_data[slc_pkg::TAP_COUNT_W-1:0];
				slc_pkg::REG_SCALE:     scale_q     <= cfg_data[slc_pkg::SCALE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// The sequencer steps all three lanes in lock-step through the taps.
	slc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.cmd       (s_tuser),
		.tap_index (tap_index),
		.tap_count (tap_count_q),
		.out_free  (out_free),
		.ctl       (ctl)
	);

	// One lane per colour channel.
	slc_lane u_lane_r (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.wdata  (val_r),
		.scale  (scale_q),
		.res    (res_r)
	);

	slc_lane u_lane_g (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.wdata  (val_g),
		.scale  (scale_q),
		.res    (res_g)
	);

	slc_lane u_lane_b (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.wdata  (val_b),
		.scale  (scale_q),
		.res    (res_b)
	);

	// The merging stage combines the lane results and owns the output register.
	slc_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_r    (res_r),
		.res_g    (res_g),
		.res_b    (res_b),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.out_free (out_free)
	);

endmodule

`default_nettype wire

/* dv/tb_top.sv */
// Self-checking testbench for scaled_linear_convolution_top: directed rows, then random runs.
// Depends on rtl/slc_pkg.sv and the RTL of the block; needs no files or arguments.
`default_nettype none

module tb_top;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int ITEM_TARGET    = 700;
	localparam logic [slc_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

	typedef struct packed {
		logic [slc_pkg::OUT_W-1:0] r;
		logic [slc_pkg::OUT_W-1:0] g;
		logic [slc_pkg::OUT_W-1:0] b;
		logic                      sat;
	} conv_out_t;

	typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

	typedef struct {
		row_kind_t                      kind;
		logic [slc_pkg::CMD_W-1:0]      cmd;
		logic [slc_pkg::IDX_W-1:0]      idx;
		logic [slc_pkg::VAL_W-1:0]      r;
		logic [slc_pkg::VAL_W-1:0]      g;
		logic [slc_pkg::VAL_W-1:0]      b;
		logic [slc_pkg::CFG_IDX_W-1:0]  reg_idx;
		logic [slc_pkg::CFG_DATA_W-1:0] reg_data;
		bit                             typed;
		conv_out_t                      out;
	} row_t;

	typedef enum {RDY_ALWAYS, RDY_TOGGLE, RDY_RANDOM, RDY_BURSTS} ready_mode_t;

	logic                            clk       = 1'b0;
	logic                            arst_n    = 1'b0;
	logic                            s_tvalid  = 1'b0;
	wire                             s_tready;
	logic [55:0]                     s_tdata   = '0;
	logic [slc_pkg::CMD_W-1:0]       s_tuser   = '0;
	wire                             m_tvalid;
	logic                            m_tready  = 1'b0;
	wire  [3*slc_pkg::OUT_W-1:0]     m_tdata;
	wire                             m_tuser;
	logic                            cfg_we    = 1'b0;
	logic [slc_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
	logic [slc_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

	scaled_linear_convolution_top uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow copy of the block's state and registers.
	logic [slc_pkg::VAL_W-1:0]       tap_mem  [slc_pkg::MAX_TAPS][3];
	logic [slc_pkg::VAL_W-1:0]       hist_mem [slc_pkg::MAX_TAPS][3];
	logic [slc_pkg::TAP_COUNT_W-1:0] tap_count_q = slc_pkg::TAP_COUNT_RST;
	logic [slc_pkg::SCALE_W-1:0]     scale_q     = slc_pkg::SCALE_RST;

	conv_out_t   pending_sums [$];
	row_t        directed_rows [$];
	bit          typed_pending = 1'b0;
	conv_out_t   typed_output  = '0;
	int          mismatch_count = 0;
	int          idle_cycles    = 0;
	int          items_sent     = 0;
	int          burst_left     = 0;
	ready_mode_t ready_mode     = RDY_ALWAYS;
	int          ready_timer    = 0;
	int          stall_left     = 0;

	function automatic int taps_in_use();
		if (tap_count_q == 0)
			return 1;
		if (tap_count_q > slc_pkg::MAX_TAPS)
			return slc_pkg::MAX_TAPS;
		return int'(tap_count_q);
	endfunction

	// Applies one transaction to the shadow state; returns 1 with the scaled sums for a push.
	function automatic bit convolve_item(input logic [slc_pkg::CMD_W-1:0] cmd,
			input logic [slc_pkg::IDX_W-1:0] idx, input logic [slc_pkg::VAL_W-1:0] vr,
			input logic [slc_pkg::VAL_W-1:0] vg, input logic [slc_pkg::VAL_W-1:0] vb,
			output conv_out_t res);
		logic [slc_pkg::VAL_W-1:0] v [3];
		logic [63:0]               acc;
		logic [63:0]               scaled;
		logic [slc_pkg::OUT_W-1:0] o [3];
		bit                        sat;
		int                        n;
		v[0] = vr & slc_pkg::VAL_MASK;
		v[1] = vg & slc_pkg::VAL_MASK;
		v[2] = vb & slc_pkg::VAL_MASK;
		res = '0;
		sat = 1'b0;
		if (cmd == slc_pkg::CMD_TAP) begin
			for (int c = 0; c < 3; c++)
				tap_mem[idx][c] = v[c];
			return 1'b0;
		end
		if (cmd == slc_pkg::CMD_CLEAR) begin
			for (int j = 0; j < slc_pkg::MAX_TAPS; j++)
				for (int c = 0; c < 3; c++)
					hist_mem[j][c] = '0;
			return 1'b0;
		end
		if (cmd != slc_pkg::CMD_PUSH)
			return 1'b0;
		for (int j = slc_pkg::MAX_TAPS - 1; j > 0; j--)
			for (int c = 0; c < 3; c++)
				hist_mem[j][c] = hist_mem[j-1][c];
		for (int c = 0; c < 3; c++)
			hist_mem[0][c] = v[c];
		n = taps_in_use();
		for (int c = 0; c < 3; c++) begin
			acc = '0;
			for (int j = 0; j < n; j++)
				acc += 64'(tap_mem[j][c]) * 64'(hist_mem[j][c]);
			// Q8.32 sum times Q0.16 scale, rounded half up back to Q8.16.
			scaled = acc * 64'(scale_q) + (64'd1 << (slc_pkg::SHIFT - 1));
			if (scaled >= (64'd1 << (slc_pkg::SHIFT + 24))) begin
				o[c] = slc_pkg::OUT_MAX;
				sat = 1'b1;
			end else begin
				o[c] = scaled[slc_pkg::SHIFT +: slc_pkg::OUT_W];
			end
		end
		res.r = o[0];
		res.g = o[1];
		res.b = o[2];
		res.sat = sat;
		return 1'b1;
	endfunction

	task automatic report_mismatch(input string what, input logic [slc_pkg::OUT_W-1:0] got,
			input logic [slc_pkg::OUT_W-1:0] want);
		mismatch_count++;
		$display("%0t: %s: got %h, wanted %h", $time, what, got, want);
	endtask

	// Output check first, then the input transaction of the same edge, then the watchdog.
	always @(posedge clk) begin
		conv_out_t sum;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (pending_sums.size() == 0) begin
					report_mismatch("output with nothing pending",
						m_tdata[slc_pkg::OUT_W-1:0], '0);
				end else begin
					sum = pending_sums.pop_front();
					if (m_tdata[0 +: slc_pkg::OUT_W] !== sum.r)
						report_mismatch("out_r", m_tdata[0 +: slc_pkg::OUT_W], sum.r);
					if (m_tdata[slc_pkg::OUT_W +: slc_pkg::OUT_W] !== sum.g)
						report_mismatch("out_g", m_tdata[slc_pkg::OUT_W +: slc_pkg::OUT_W],
							sum.g);
					if (m_tdata[2*slc_pkg::OUT_W +: slc_pkg::OUT_W] !== sum.b)
						report_mismatch("out_b", m_tdata[2*slc_pkg::OUT_W +: slc_pkg::OUT_W],
							sum.b);
					if (m_tuser !== sum.sat)
						report_mismatch("saturated", slc_pkg::OUT_W'(m_tuser),
							slc_pkg::OUT_W'(sum.sat));
				end
			end
			if (s_tvalid && s_tready) begin
				if (convolve_item(s_tuser, s_tdata[7:0], s_tdata[23:8], s_tdata[39:24],
						s_tdata[55:40], sum))
					pending_sums.insert(pending_sums.size(), typed_pending ? typed_output : sum);
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	// The receiver switches between random stall patterns at random intervals.
	always @(negedge clk) begin
		if (ready_timer == 0) begin
			ready_mode = ready_mode_t'($urandom_range(0, 3));
			ready_timer = $urandom_range(20, 120);
		end
		ready_timer--;
		case (ready_mode)
			RDY_ALWAYS: m_tready <= 1'b1;
			RDY_TOGGLE: m_tready <= ~m_tready;
			RDY_RANDOM: m_tready <= ($urandom_range(0, 9) < 7);
			default: begin
				if (stall_left > 0) begin
					stall_left--;
					m_tready <= 1'b0;
				end else if ($urandom_range(0, 7) == 0) begin
					stall_left = $urandom_range(1, 15);
					m_tready <= 1'b0;
				end else begin
					m_tready <= 1'b1;
				end
			end
		endcase
	end

	function automatic logic [slc_pkg::VAL_W-1:0] rand_val();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return slc_pkg::VAL_W'($urandom);
		endcase
	endfunction

	// Called at a falling edge; returns at the falling edge after acceptance with valid still high.
	task automatic send_item(input logic [slc_pkg::CMD_W-1:0] cmd,
			input logic [slc_pkg::IDX_W-1:0] idx, input logic [slc_pkg::VAL_W-1:0] r,
			input logic [slc_pkg::VAL_W-1:0] g, input logic [slc_pkg::VAL_W-1:0] b);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 3) == 0) ? 64 : $urandom_range(1, 24);
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {b, g, r, idx};
		do
			@(posedge clk);
		while (!s_tready);
		@(negedge clk);
		typed_pending = 1'b0;
		if (cmd != CMD_UNUSED)
			items_sent++;
	endtask

	// Holds the sender off until every pending output has arrived and the block has settled.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_sums.size() != 0)
			@(negedge clk);
		repeat (taps_in_use() + 10) @(negedge clk);
	endtask

	task automatic write_reg(input logic [slc_pkg::CFG_IDX_W-1:0] ri,
			input logic [slc_pkg::CFG_DATA_W-1:0] d);
		drain();
		cfg_we    <= 1'b1;
		cfg_index <= ri;
		cfg_data  <= d;
		if (ri == slc_pkg::REG_TAP_COUNT)
			tap_count_q = d[slc_pkg::TAP_COUNT_W-1:0];
		else
			scale_q = d[slc_pkg::SCALE_W-1:0];
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	function automatic void add_item(input logic [slc_pkg::CMD_W-1:0] cmd,
			input logic [slc_pkg::IDX_W-1:0] idx, input logic [slc_pkg::VAL_W-1:0] r,
			input logic [slc_pkg::VAL_W-1:0] g, input logic [slc_pkg::VAL_W-1:0] b,
			input bit typed = 1'b0, input logic [slc_pkg::OUT_W-1:0] want = '0);
		row_t row;
		row.kind = ROW_ITEM;
		row.cmd = cmd;
		row.idx = idx;
		row.r = r;
		row.g = g;
		row.b = b;
		row.reg_idx = '0;
		row.reg_data = '0;
		row.typed = typed;
		row.out = '{r: want, g: want, b: want, sat: 1'b0};
		directed_rows.insert(directed_rows.size(), row);
	endfunction

	function automatic void add_reg(input logic [slc_pkg::CFG_IDX_W-1:0] ri,
			input logic [slc_pkg::CFG_DATA_W-1:0] d);
		row_t row;
		row = '{kind: ROW_REG, cmd: slc_pkg::CMD_TAP, idx: '0, r: '0, g: '0, b: '0,
			reg_idx: ri, reg_data: d, typed: 1'b0, out: '0};
		directed_rows.insert(directed_rows.size(), row);
	endfunction

	initial begin
		logic [slc_pkg::TAP_COUNT_W-1:0] tc;
		logic [6:0]                      hi_bits;
		logic [slc_pkg::SCALE_W-1:0]     sc;
		int                              n;
		int                              k;
		int                              tail;
		int                              pick;
		int                              phase;

		for (int j = 0; j < slc_pkg::MAX_TAPS; j++)
			for (int c = 0; c < 3; c++) begin
				tap_mem[j][c] = '0;
				hist_mem[j][c] = '0;
			end

		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed rows. With one tap of full scale and scale 655, a full-scale sample
		// gives 655 in every channel; zero samples and a zero scale give zero.
		add_item(slc_pkg::CMD_TAP, 8'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		add_item(slc_pkg::CMD_PUSH, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 24'd655);
		add_item(slc_pkg::CMD_PUSH, 8'h00, 16'h0000, 16'h0000, 16'h0000, 1'b1, 24'd0);
		add_item(slc_pkg::CMD_TAP, 8'd255, 16'h5A5A, 16'hA5A5, 16'h0001);
		add_item(CMD_UNUSED, 8'hAA, 16'h1234, 16'hFFFF, 16'h8000);
		add_item(slc_pkg::CMD_TAP, 8'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		add_item(slc_pkg::CMD_TAP, 8'd2, 16'h0000, 16'h8000, 16'h0001);
		add_item(slc_pkg::CMD_PUSH, 8'h55, 16'h8000, 16'h0001, 16'hFFFF);
		add_item(slc_pkg::CMD_CLEAR, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		add_item(slc_pkg::CMD_PUSH, 8'h00, 16'h0000, 16'h0000, 16'h0000, 1'b1, 24'd0);
		add_reg(slc_pkg::REG_SCALE, 16'h0000);
		add_item(slc_pkg::CMD_PUSH, 8'h00, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 24'd0);
		add_reg(slc_pkg::REG_SCALE, 16'hFFFF);
		add_item(slc_pkg::CMD_PUSH, 8'h00, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		// A tap count of zero behaves as one.
		add_reg(slc_pkg::REG_TAP_COUNT, 16'd0);
		add_item(slc_pkg::CMD_PUSH, 8'h0F, 16'h0001, 16'h0002, 16'h0003);
		add_reg(slc_pkg::REG_TAP_COUNT, 16'd3);
		add_item(slc_pkg::CMD_CLEAR, 8'h00, 16'h0000, 16'h0000, 16'h0000);
		add_item(slc_pkg::CMD_PUSH, 8'h00, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		add_item(slc_pkg::CMD_PUSH, 8'h00, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		add_item(slc_pkg::CMD_PUSH, 8'h00, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		add_item(slc_pkg::CMD_PUSH, 8'h00, 16'h0000, 16'h0000, 16'h0000);
		add_item(slc_pkg::CMD_PUSH, 8'h00, 16'h0000, 16'h0000, 16'h0000);
		add_reg(slc_pkg::REG_SCALE, 16'd655);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_REG) begin
				write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_data);
			end else begin
				typed_pending = directed_rows[i].typed;
				typed_output = directed_rows[i].out;
				send_item(directed_rows[i].cmd, directed_rows[i].idx, directed_rows[i].r,
					directed_rows[i].g, directed_rows[i].b);
			end
		end

		// Fill the whole tap store so that any tap count reads written entries only.
		for (int j = 0; j < slc_pkg::MAX_TAPS; j++)
			send_item(slc_pkg::CMD_TAP, slc_pkg::IDX_W'(j), rand_val(), rand_val(), rand_val());

		phase = 0;
		while (items_sent < ITEM_TARGET) begin
			case (phase)
				0: begin tc = 9'd256; sc = 16'hFFFF; end
				1: begin tc = 9'd511; sc = 16'h0000; end
				2: begin tc = 9'd1;   sc = 16'hFFFF; end
				default: begin
					pick = $urandom_range(0, 19);
					if (pick == 0)
						tc = 9'd0;
					else if (pick == 1)
						tc = 9'd256;
					else if (pick == 2)
						tc = slc_pkg::TAP_COUNT_W'($urandom_range(257, 511));
					else if (pick < 5)
						tc = slc_pkg::TAP_COUNT_W'($urandom_range(9, 40));
					else
						tc = slc_pkg::TAP_COUNT_W'($urandom_range(1, 8));
					case ($urandom_range(0, 5))
						0: sc = 16'h0000;
						1: sc = 16'hFFFF;
						2: sc = 16'd655;
						default: sc = slc_pkg::SCALE_W'($urandom);
					endcase
				end
			endcase
			// Bits above the register width are set now and then; they must be ignored.
			hi_bits = ($urandom_range(0, 1) == 0) ? 7'd0 : 7'($urandom);
			write_reg(slc_pkg::REG_TAP_COUNT, {hi_bits, tc});
			write_reg(slc_pkg::REG_SCALE, sc);
			n = taps_in_use();

			if ($urandom_range(0, 9) < 6) begin
				// A convolution: load taps (only when at most 16 are in use), clear, push samples, then a tail of zeros.
				if (n <= 16)
					for (int j = 0; j < n; j++)
						send_item(slc_pkg::CMD_TAP, slc_pkg::IDX_W'(j), rand_val(), rand_val(),
							rand_val());
				send_item(slc_pkg::CMD_CLEAR, slc_pkg::IDX_W'($urandom), rand_val(), rand_val(),
					rand_val());
				k = (n > 40) ? $urandom_range(1, 3) : $urandom_range(1, 12);
				repeat (k)
					send_item(slc_pkg::CMD_PUSH, slc_pkg::IDX_W'($urandom), rand_val(),
						rand_val(), rand_val());
				tail = (n > 21) ? 6 : n - 1;
				repeat (tail)
					send_item(slc_pkg::CMD_PUSH, slc_pkg::IDX_W'($urandom), '0, '0, '0);
			end else begin
				k = (n > 40) ? 4 : $urandom_range(10, 30);
				for (int j = 0; j < k; j++) begin
					if (j == k / 2 && $urandom_range(0, 3) == 0)
						drain();
					pick = $urandom_range(0, 99);
					if (pick < 55)
						send_item(slc_pkg::CMD_PUSH, slc_pkg::IDX_W'($urandom), rand_val(),
							rand_val(), rand_val());
					else if (pick < 75)
						send_item(slc_pkg::CMD_TAP, slc_pkg::IDX_W'($urandom), rand_val(),
							rand_val(), rand_val());
					else if (pick < 85)
						send_item(slc_pkg::CMD_CLEAR, slc_pkg::IDX_W'($urandom), rand_val(),
							rand_val(), rand_val());
					else if (pick < 92)
						send_item(CMD_UNUSED, slc_pkg::IDX_W'($urandom), rand_val(),
							rand_val(), rand_val());
					else
						send_item(slc_pkg::CMD_PUSH, slc_pkg::IDX_W'($urandom), '0, '0, '0);
				end
			end
			phase++;
		end

		drain();
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

`default_nettype wire

/* sim.f */
rtl/slc_pkg.sv
rtl/slc_ctrl.sv
rtl/slc_lane.sv
rtl/slc_merge.sv
rtl/scaled_linear_convolution_top.sv
dv/tb_top.sv
